### design/ring_buffer_deque_macros.svh
// Assertion macros for the ring buffer deque.
// Included by the RTL files that check their own logic; expects clk and rst_n in scope.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// same-cycle implication
`define RBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/rbd_pkg.sv
// Package for the ring buffer deque: operation and status codes, word type,
// pending-result record. No dependencies.
package rbd_pkg;

  typedef logic signed [31:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    FN_PUSH_BACK  = 2'd0,
    FN_PUSH_FRONT = 2'd1,
    FN_POP_BACK   = 2'd2,
    FN_POP_FRONT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        mem_rd;
    logic [3:0]  occupancy;
    logic        is_full;
    logic        is_empty;
  } res_t;

endpackage

### design/ring_buffer_deque.sv
// Ring buffer deque top level: control registers, pending stage, output register.
// Depends on rbd_pkg, rbd_store and ring_buffer_deque_macros.svh.
//
// A double-ended queue of DEPTH signed 32-bit words held in a circular slot
// memory, with a front index and an element count in registers. Each input
// transaction carries an operation in in_tuser (push back, push front, pop back,
// pop front) and the word to push in in_tdata; each produces exactly one result
// transaction with the popped value, a status (ok, overflow, underflow), and
// the occupancy and full/empty flags after the operation. A push to a full queue
// or a pop from an empty one leaves the state unchanged; an empty pop returns
// 2147483647. The block takes one operation per cycle while results are drained;
// out_tvalid rises when the output register is loaded: the edge that accepts the
// operation captures the registered slot read and the pending record, and the
// output register is loaded from them once it is empty or being drained. A push
// followed directly by a pop of the same slot is safe, as the write lands before
// the read. Slot contents are not cleared at reset and no clearing pass runs.
module ring_buffer_deque #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value, [35:32] occupancy, [36] is_full,
                                  // [37] is_empty, [39:38] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import rbd_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r, pend_nxt;
  res_t          pres_r, pres_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_value_r, out_value_nxt;
  res_t          ores_r, ores_nxt;

  logic          in_fire, move;
  logic          full, empty, push_ok;
  func_t         func;
  word_t         item, rd_data;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [IW-1:0] front_dec, front_inc, tail_idx, back_idx;
  logic [SW-1:0] tail_sum, back_sum;

  assign func    = func_t'(in_tuser);
  assign item    = word_t'(in_tdata);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign move    = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || move;
  assign in_fire = in_tvalid && in_tready;
  assign push_ok = !full && (func == FN_PUSH_BACK || func == FN_PUSH_FRONT);

  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign tail_sum  = SW'(front_r) + SW'(count_r);
  assign back_sum  = SW'(front_r) + SW'(count_r - 1'b1);
  assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    rd_en     = 1'b0;
    rd_addr   = back_idx;
    pres_nxt  = pres_r;
    pend_nxt  = pend_r && !move;
    if (in_fire) begin
      pend_nxt        = 1'b1;
      pres_nxt.status = ST_OK;
      pres_nxt.mem_rd = 1'b0;
      unique case (func)
        FN_PUSH_BACK: begin
          if (full) begin
            pres_nxt.status = ST_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        FN_PUSH_FRONT: begin
          if (full) begin
            pres_nxt.status = ST_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        FN_POP_BACK: begin
          if (empty) begin
            pres_nxt.status = ST_UNDERFLOW;
          end else begin
            rd_en           = 1'b1;
            pres_nxt.mem_rd = 1'b1;
            count_nxt       = count_r - 1'b1;
          end
        end
        default: begin
          if (empty) begin
            pres_nxt.status = ST_UNDERFLOW;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = front_r;
            pres_nxt.mem_rd = 1'b1;
            front_nxt       = front_inc;
            count_nxt       = count_r - 1'b1;
          end
        end
      endcase
      pres_nxt.occupancy = 4'(count_nxt);
      pres_nxt.is_full   = (count_nxt == CW'(DEPTH));
      pres_nxt.is_empty  = (count_nxt == '0);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    ores_nxt      = ores_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      ores_nxt      = pres_r;
      if (pres_r.mem_rd) begin
        out_value_nxt = rd_data;
      end else if (pres_r.status == ST_UNDERFLOW) begin
        out_value_nxt = WORD_MAX;
      end else begin
        out_value_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pres_r      <= pres_nxt;
    ores_r      <= ores_nxt;
    out_value_r <= out_value_nxt;
  end

  rbd_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, ores_r.is_empty, ores_r.is_full, ores_r.occupancy,
                       out_value_r};
  assign out_tuser  = ores_r.status;

`include "ring_buffer_deque_macros.svh"

  `RBD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "element count above depth")
  `RBD_ASSERT_IMP(a_front_bound, 1'b1, front_r <= IW'(DEPTH - 1), "front index out of range")
  `RBD_ASSERT_NXT(a_push_count, in_fire && push_ok, count_r == $past(count_r) + 1'b1, "push lost")
  `RBD_ASSERT_NXT(a_pend_moves, pend_r && !out_valid_r, out_valid_r, "pending result stuck")

endmodule

### design/rbd_store.sv
// Slot memory of the ring buffer deque: one write port, one registered read port.
// Depends on rbd_pkg.
module rbd_store #(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  rbd_pkg::word_t  wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output rbd_pkg::word_t  rd_data
);
  import rbd_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sim/tb_ring_buffer_deque.sv
// Testbench for ring_buffer_deque: directed and random deque operations over
// the in_/out_ streams, every result checked against a local deque model.
// Depends on rbd_pkg and the ring_buffer_deque RTL.
`timescale 1ns / 100ps

module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int DEPTH = 8;
  localparam int N_RANDOM = 2000;

  typedef struct {
    func_t func;
    word_t data;
    bit    drain;
  } deque_op_t;

  typedef struct {
    word_t      value;
    status_t    status;
    logic [3:0] occupancy;
    logic       is_full;
    logic       is_empty;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  deque_op_t     op_queue[$];
  deque_result_t exp_results[$];

  word_t deque_slots[DEPTH];
  int    head_idx = 0;
  int    elem_cnt = 0;

  int err_cnt = 0;
  int n_total = 0;
  int n_accepted = 0;

  int tx_gap = 0, tx_phase = 0;
  bit tx_quiet = 1'b0;
  int rx_gap = 0, rx_phase = 0;
  bit rx_quiet = 1'b0;

  ring_buffer_deque #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_idle(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic add_op(input func_t f, input word_t d, input bit drain);
    deque_op_t op;
    op.func = f;
    op.data = d;
    op.drain = drain;
    op_queue.insert(op_queue.size(), op);
    n_total++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic apply_deque_op(input func_t f, input word_t d);
    deque_result_t r;
    int slot;
    r.value = '0;
    r.status = ST_OK;
    case (f)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (elem_cnt == DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (f == FN_PUSH_BACK) begin
          slot = (head_idx + elem_cnt) % DEPTH;
          deque_slots[slot] = d;
          elem_cnt++;
        end else begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          deque_slots[head_idx] = d;
          elem_cnt++;
        end
      end
      default: begin
        if (elem_cnt == 0) begin
          r.status = ST_UNDERFLOW;
          r.value = WORD_MAX;
        end else if (f == FN_POP_BACK) begin
          elem_cnt--;
          slot = (head_idx + elem_cnt) % DEPTH;
          r.value = deque_slots[slot];
        end else begin
          r.value = deque_slots[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          elem_cnt--;
        end
      end
    endcase
    r.occupancy = 4'(elem_cnt);
    r.is_full = (elem_cnt == DEPTH);
    r.is_empty = (elem_cnt == 0);
    exp_results.insert(exp_results.size(), r);
  endtask

  // driver
  deque_op_t nxt_op;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_deque_op(func_t'(in_tuser), word_t'(in_tdata));
        n_accepted++;
      end
      if (tx_phase == 0) begin
        tx_phase = $urandom_range(20, 200);
        tx_quiet = ($urandom_range(0, 3) == 0);
      end else begin
        tx_phase--;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].drain && exp_results.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          nxt_op = op_queue[0];
          op_queue.delete(0);
          in_tvalid <= 1'b1;
          in_tdata <= nxt_op.data;
          in_tuser <= nxt_op.func;
          tx_gap = pick_idle(tx_quiet);
        end
      end
    end
  end

  // monitor
  deque_result_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata[31:0], '0);
        end else begin
          want = exp_results[0];
          exp_results.delete(0);
          if (out_tdata[31:0] !== want.value)
            report_mismatch("value", out_tdata[31:0], want.value);
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[35:32] !== want.occupancy)
            report_mismatch("occupancy", 32'(out_tdata[35:32]), 32'(want.occupancy));
          if (out_tdata[36] !== want.is_full)
            report_mismatch("is_full", 32'(out_tdata[36]), 32'(want.is_full));
          if (out_tdata[37] !== want.is_empty)
            report_mismatch("is_empty", 32'(out_tdata[37]), 32'(want.is_empty));
        end
      end
      if (rx_phase == 0) begin
        rx_phase = $urandom_range(20, 200);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end else begin
        rx_phase--;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_gap = pick_idle(rx_quiet);
      end
    end
  end

  initial begin
    int seg_left;
    int push_pct;
    func_t f;
    seg_left = 0;
    push_pct = 50;

    // empty pops, extremes, front push wrapping below index zero
    add_op(FN_POP_BACK, 32'sd5, 1'b0);
    add_op(FN_POP_FRONT, -32'sd5, 1'b0);
    add_op(FN_PUSH_FRONT, WORD_MAX, 1'b0);
    add_op(FN_PUSH_BACK, 32'sh8000_0000, 1'b0);
    add_op(FN_PUSH_BACK, '0, 1'b0);
    add_op(FN_PUSH_FRONT, -32'sd1, 1'b0);
    add_op(FN_PUSH_BACK, 32'sh5555_5555, 1'b0);
    add_op(FN_PUSH_FRONT, 32'sh2AAA_AAAA, 1'b0);
    add_op(FN_PUSH_BACK, 32'sh0F0F_0F0F, 1'b0);
    add_op(FN_PUSH_FRONT, 32'sh7070_7070, 1'b0);
    // full: both pushes overflow
    add_op(FN_PUSH_BACK, 32'sd11, 1'b0);
    add_op(FN_PUSH_FRONT, 32'sd12, 1'b0);
    add_op(FN_POP_FRONT, '0, 1'b0);
    add_op(FN_POP_BACK, '0, 1'b0);
    add_op(FN_POP_FRONT, '0, 1'b0);
    add_op(FN_POP_BACK, '0, 1'b0);
    add_op(FN_POP_FRONT, '0, 1'b0);
    add_op(FN_POP_BACK, '0, 1'b0);
    add_op(FN_POP_FRONT, '0, 1'b0);
    add_op(FN_POP_BACK, '0, 1'b0);
    add_op(FN_POP_BACK, '0, 1'b0);
    add_op(FN_POP_FRONT, '0, 1'b0);
    // hold off until the pipeline is empty, then push a word and pop it again
    add_op(FN_PUSH_BACK, 32'sd77, 1'b1);
    add_op(FN_POP_FRONT, '0, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(6, 24);
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      seg_left--;
      if ($urandom_range(0, 99) < push_pct)
        f = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      else
        f = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
      add_op(f, rand_word(), $urandom_range(0, 199) == 0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total) @(posedge clk);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
